>>> src/bba_pkg.sv
package bba_pkg;

  // Map geometry: the used map is held as words of this many bits.
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned BIT_W        = $clog2(WORD_W);
  localparam int unsigned MAP_BITS_DEF = 4096;

  // Free counter width and its absolute ceiling.
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned CNT_MAX = 8191;

  // Block number and geometry register width.
  localparam int unsigned BLK_W = 16;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Commands.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DATA_START = 2'd0;
  localparam logic [1:0] CFG_TOTAL      = 2'd1;
  localparam logic [1:0] CFG_INIT_FREE  = 2'd2;

  // Result of one command handed from the engine to the top level.
  typedef struct packed {
    logic [1:0]       status;
    logic [BLK_W-1:0] block;
    logic             inc;
    logic             dec;
  } res_t;

  // Index of the lowest set bit of a word (zero if none is set).
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> src/bba_ram.sv
module bba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/bba_engine.sv
module bba_engine import bba_pkg::*; #(
  parameter int unsigned MAP_BITS = MAP_BITS_DEF,
  localparam int unsigned N_W     = $clog2(MAP_BITS + 1),
  localparam int unsigned DEPTH   = (MAP_BITS + WORD_W - 1) / WORD_W,
  localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  logic             cmd_i,
  input  logic [BLK_W-1:0] blk_i,
  input  logic [BLK_W-1:0] start_i,
  input  logic [N_W-1:0]   count_i,
  input  logic             slot_free_i,
  output logic             done_o,
  output res_t             res_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FREE  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [AW-1:0]    clr_idx_q, clr_idx_d;
  logic [AW-1:0]    rd_idx_q, rd_idx_d;
  logic [AW-1:0]    wr_idx_q, wr_idx_d;
  logic [BIT_W-1:0] bit_q, bit_d;
  res_t             res_q, res_d;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic [BLK_W:0]    off;
  logic              in_range;
  logic [BLK_W:0]    rem;
  logic [WORD_W-1:0] valid_mask;
  logic [WORD_W-1:0] free_bits;
  logic              last_word;
  logic              hit;
  logic [BIT_W-1:0]  hit_idx;
  logic              accept;

  bba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign req_ready_o = (state_q == S_IDLE);
  assign accept      = req_valid_i && req_ready_o;

  // Range check of a block to free against the data region.
  assign off      = {1'b0, blk_i} - {1'b0, start_i};
  assign in_range = (blk_i >= start_i) && (off < (BLK_W + 1)'(count_i));

  // Bits of the current word that lie below the data count.
  assign rem        = (BLK_W + 1)'(count_i) - (BLK_W + 1)'({rd_idx_q, {BIT_W{1'b0}}});
  assign last_word  = rem <= (BLK_W + 1)'(WORD_W);
  assign valid_mask = (rem >= (BLK_W + 1)'(WORD_W)) ? {WORD_W{1'b1}} :
                      ((WORD_W'(1) << rem[BIT_W-1:0]) - WORD_W'(1));
  assign free_bits  = ~ram_rdata & valid_mask;
  assign hit        = |free_bits;
  assign hit_idx    = lowest_set(free_bits);

  // Read address: the word to free, or the next word of the scan.
  always_comb begin
    ram_raddr = rd_idx_q;
    if (state_q == S_IDLE) begin
      ram_raddr = (cmd_i == CMD_FREE) ? off[AW+BIT_W-1:BIT_W] : '0;
    end else if (state_q == S_SCAN && !last_word) begin
      ram_raddr = rd_idx_q + AW'(1);
    end
  end

  // Sequencer: clearing pass, free read-modify-write, allocate scan.
  always_comb begin
    state_d   = state_q;
    clr_idx_d = clr_idx_q;
    rd_idx_d  = rd_idx_q;
    wr_idx_d  = wr_idx_q;
    bit_d     = bit_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = clr_idx_q;
    ram_wdata = '0;
    done_o    = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        clr_idx_d = clr_idx_q + AW'(1);
        if (clr_idx_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_d = '{status: ST_OK, block: '0, inc: 1'b0, dec: 1'b0};
          if (cmd_i == CMD_FREE) begin
            if (in_range) begin
              wr_idx_d = off[AW+BIT_W-1:BIT_W];
              bit_d    = off[BIT_W-1:0];
              state_d  = S_FREE;
            end else begin
              res_d.status = ST_RANGE;
              state_d      = S_EMIT;
            end
          end else if (count_i == '0) begin
            res_d.status = ST_FULL;
            state_d      = S_EMIT;
          end else begin
            rd_idx_d = '0;
            state_d  = S_SCAN;
          end
        end
      end
      S_FREE: begin
        ram_we    = 1'b1;
        ram_waddr = wr_idx_q;
        ram_wdata = ram_rdata & ~(WORD_W'(1) << bit_q);
        res_d.inc = 1'b1;
        state_d   = S_EMIT;
      end
      S_SCAN: begin
        if (hit) begin
          ram_we      = 1'b1;
          ram_waddr   = rd_idx_q;
          ram_wdata   = ram_rdata | (WORD_W'(1) << hit_idx);
          res_d.dec   = 1'b1;
          res_d.block = BLK_W'({1'b0, start_i} + (BLK_W + 1)'({rd_idx_q, hit_idx}));
          state_d     = S_EMIT;
        end else if (last_word) begin
          res_d.status = ST_FULL;
          state_d      = S_EMIT;
        end else begin
          rd_idx_d = rd_idx_q + AW'(1);
        end
      end
      S_EMIT: begin
        if (slot_free_i) begin
          done_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_idx_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    wr_idx_q <= wr_idx_d;
    bit_q    <= bit_d;
    res_q    <= res_d;
  end

  assign res_o = res_q;

endmodule

>>> src/block_bitmap_allocator.sv
// Channel   Direction  Bits  Contents
// s_axis    in         1+16  tuser: command; tdata: block_number
// m_axis    out        32    tdata: status, allocated_block, free_remaining
// cfg       in         2+16  register index, write data
//
// A free request is accepted, then its map word is read and written back before the result is formed.
// A free outside the data region, or an allocate with a zero data count, skips the map.
// An allocate request scans the 32-bit map words in order until one has a clear bit;
// the single map read port walks one word per cycle, up to ceil(count/32).
// After reset a clearing pass writes every map word once, and no request is accepted
// until it ends.
// A finished result waits in the output register; the next request is accepted
// meanwhile, and its own result is held back until the register is taken.
module block_bitmap_allocator import bba_pkg::*; #(
  parameter int unsigned MAP_BITS = MAP_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [15:0]      s_axis_tdata_i,  // [15:0] block_number
  input  logic [0:0]       s_axis_tuser_i,  // [0] command
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // [1:0] status, [17:2] allocated_block, [30:18] free_remaining, [31] zero
  output logic [31:0]      m_axis_tdata_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [BLK_W-1:0] cfg_data_i
);

  localparam int unsigned N_W = $clog2(MAP_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_CAP =
      (MAP_BITS < CNT_MAX) ? CNT_W'(MAP_BITS) : CNT_W'(CNT_MAX);

  logic [BLK_W-1:0] start_q;
  logic [BLK_W-1:0] total_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             m_valid_q;
  logic [31:0]      m_data_q;

  logic [BLK_W:0]   span;
  logic [N_W-1:0]   count;
  logic             slot_free;
  logic             eng_done;
  res_t             eng_res;

  // Data count: total minus start, zero when negative, capped at the map size.
  assign span  = (total_q > start_q) ? ({1'b0, total_q} - {1'b0, start_q}) : '0;
  assign count = (span > (BLK_W + 1)'(MAP_BITS)) ? N_W'(MAP_BITS) : N_W'(span);

  assign slot_free = !m_valid_q || m_axis_tready_i;

  bba_engine #(
    .MAP_BITS (MAP_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .cmd_i       (s_axis_tuser_i[0]),
    .blk_i       (s_axis_tdata_i),
    .start_i     (start_q),
    .count_i     (count),
    .slot_free_i (slot_free),
    .done_o      (eng_done),
    .res_o       (eng_res)
  );

  // Free counter: loaded by a register write, stepped by completed requests.
  always_comb begin
    cnt_d = cnt_q;
    if (cfg_we_i && cfg_idx_i == CFG_INIT_FREE) begin
      cnt_d = cfg_data_i[CNT_W-1:0];
    end else if (eng_done) begin
      if (eng_res.inc && cnt_q < CNT_CAP) begin
        cnt_d = cnt_q + CNT_W'(1);
      end else if (eng_res.dec && cnt_q != '0) begin
        cnt_d = cnt_q - CNT_W'(1);
      end
    end
  end

  // Configuration registers and counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      total_q <= BLK_W'(4096);
      cnt_q   <= CNT_W'(4096);
    end else begin
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DATA_START: start_q <= cfg_data_i;
          CFG_TOTAL:      total_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (eng_done) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_done) begin
      m_data_q <= {1'b0, cnt_d, eng_res.block, eng_res.status};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // A result is only handed over when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_done |-> slot_free)
    else $error("result completed while the output register was occupied");

  // Only defined status codes leave the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[1:0] == ST_OK || m_axis_tdata_o[1:0] == ST_FULL ||
                         m_axis_tdata_o[1:0] == ST_RANGE))
    else $error("undefined status code on the output");

  // The counter moves only on a completed request or a counter load.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!eng_done && !(cfg_we_i && cfg_idx_i == CFG_INIT_FREE)) |=> cnt_q == $past(cnt_q))
    else $error("free counter changed without a request or a load");

endmodule

>>> verif/bba_alloc_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and register channels of the allocator, keeps
// its own copy of the used map, the free counter and the volume geometry, and
// checks every result against the prediction made when its request was taken.
module bba_alloc_checker import bba_pkg::*; #(
  parameter int unsigned MAP_BITS = MAP_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  logic             req_ready_i,
  input  logic [15:0]      req_data_i,  // [15:0] block_number
  input  logic [0:0]       req_user_i,  // [0] command
  input  logic             rsp_valid_i,
  input  logic             rsp_ready_i,
  // [1:0] status, [17:2] allocated_block, [30:18] free_remaining, [31] zero
  input  logic [31:0]      rsp_data_i,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [BLK_W-1:0] cfg_data_i,
  output int               outstanding_o,
  output int               fail_count_o
);

  // The free counter stops at the map size, or at its own ceiling if smaller.
  localparam int unsigned FREE_CAP = (MAP_BITS < CNT_MAX) ? MAP_BITS : CNT_MAX;

  typedef struct packed {
    logic [1:0]       status;
    logic [BLK_W-1:0] block;
    logic [CNT_W-1:0] free_left;
  } alloc_result_t;

  logic             block_used [MAP_BITS];
  logic [BLK_W-1:0] shadow_start;
  logic [BLK_W-1:0] shadow_total;
  logic [CNT_W-1:0] shadow_free;
  alloc_result_t    alloc_results_q [$];
  int               failures = 0;

  assign fail_count_o = failures;

  // Applies one request to the shadow map and counter and returns its result.
  task automatic predict_allocation(input logic cmd, input logic [BLK_W-1:0] blk,
                                    output alloc_result_t res);
    int unsigned region;
    int unsigned first_free;
    bit          found;
    region     = (shadow_total > shadow_start) ?
                 int'(shadow_total) - int'(shadow_start) : 0;
    first_free = 0;
    found      = 1'b0;
    res        = '0;
    res.status = ST_OK;
    if (region > MAP_BITS) begin
      region = MAP_BITS;
    end
    if (cmd == CMD_ALLOC) begin
      // First fit: the lowest clear bit inside the data region wins.
      for (int i = 0; i < region; i++) begin
        if (!found && !block_used[i]) begin
          found      = 1'b1;
          first_free = i;
        end
      end
      if (found) begin
        block_used[first_free] = 1'b1;
        if (shadow_free != 0) begin
          shadow_free = shadow_free - 1'b1;
        end
        res.block = BLK_W'(int'(shadow_start) + first_free);
      end else begin
        res.status = ST_FULL;
      end
    end else begin
      // A free outside the data region changes nothing. Freeing a block that
      // is already free still bumps the counter.
      if (blk < shadow_start || int'(blk) - int'(shadow_start) >= region) begin
        res.status = ST_RANGE;
      end else begin
        block_used[int'(blk) - int'(shadow_start)] = 1'b0;
        if (shadow_free < FREE_CAP) begin
          shadow_free = shadow_free + 1'b1;
        end
      end
    end
    res.free_left = shadow_free;
  endtask

  // Results are checked before new requests are predicted: a result taken at
  // the same edge always belongs to an older request.
  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t want_res;
    alloc_result_t seen_res;
    if (!rst_ni) begin
      for (int i = 0; i < MAP_BITS; i++) begin
        block_used[i] = 1'b0;
      end
      shadow_start = '0;
      shadow_total = BLK_W'(4096);
      shadow_free  = CNT_W'(4096);
      alloc_results_q.delete();
      outstanding_o <= 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (alloc_results_q.size() == 0) begin
          $error("result 0x%08h arrived with no request outstanding", rsp_data_i);
          failures++;
        end else begin
          want_res           = alloc_results_q.pop_front();
          seen_res.status    = rsp_data_i[1:0];
          seen_res.block     = rsp_data_i[17:2];
          seen_res.free_left = rsp_data_i[30:18];
          if (seen_res.status !== want_res.status) begin
            $error("status: expected %0d, got %0d", want_res.status, seen_res.status);
            failures++;
          end
          if (seen_res.block !== want_res.block) begin
            $error("allocated_block: expected %0d, got %0d", want_res.block, seen_res.block);
            failures++;
          end
          if (seen_res.free_left !== want_res.free_left) begin
            $error("free_remaining: expected %0d, got %0d", want_res.free_left,
                   seen_res.free_left);
            failures++;
          end
          if (rsp_data_i[31] !== 1'b0) begin
            $error("padding bit: expected 0, got %b", rsp_data_i[31]);
            failures++;
          end
        end
      end

      // Register writes: a load of the initial free count reloads the counter.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DATA_START: begin
            shadow_start = cfg_data_i;
          end
          CFG_TOTAL: begin
            shadow_total = cfg_data_i;
          end
          CFG_INIT_FREE: begin
            shadow_free = cfg_data_i[CNT_W-1:0];
          end
          default: begin
          end
        endcase
      end

      if (req_valid_i && req_ready_i) begin
        predict_allocation(req_user_i[0], req_data_i, want_res);
        alloc_results_q.push_back(want_res);
      end

      outstanding_o <= alloc_results_q.size();
    end
  end

endmodule

>>> verif/block_bitmap_allocator_tb.sv
`timescale 1ns / 1ps

module block_bitmap_allocator_tb;
  import bba_pkg::*;

  localparam int unsigned STALL_LIMIT   = 3000;
  localparam int unsigned CFG_PAUSE     = 6;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned PHASE_ITEMS   = 183;

  logic             clk           = 1'b0;
  logic             rst_n         = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [15:0]      s_axis_tdata  = '0;  // [15:0] block_number
  logic [0:0]       s_axis_tuser  = '0;  // [0] command
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // [1:0] status, [17:2] allocated_block, [30:18] free_remaining, [31] zero
  logic [31:0]      m_axis_tdata;
  logic             cfg_we        = 1'b0;
  logic [1:0]       cfg_idx       = '0;
  logic [BLK_W-1:0] cfg_data      = '0;

  logic             steady_flow   = 1'b0;
  int unsigned      ready_hold    = 0;
  int unsigned      idle_cycles   = 0;
  int               outstanding;
  int               fail_count;

  block_bitmap_allocator uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  bba_alloc_checker alloc_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_i   (s_axis_tready),
    .req_data_i    (s_axis_tdata),
    .req_user_i    (s_axis_tuser),
    .rsp_valid_i   (m_axis_tvalid),
    .rsp_ready_i   (m_axis_tready),
    .rsp_data_i    (m_axis_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .outstanding_o (outstanding),
    .fail_count_o  (fail_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Result side back-pressure: mostly short ready and stall runs, a few long
  // stalls, and none at all while a phase runs at full rate.
  always @(posedge clk) begin
    int unsigned pick;
    if (steady_flow) begin
      m_axis_tready <= 1'b1;
      ready_hold    <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        m_axis_tready <= 1'b1;
        ready_hold    <= $urandom_range(0, 7);
      end else if (pick < 95) begin
        m_axis_tready <= 1'b0;
        ready_hold    <= $urandom_range(0, 3);
      end else begin
        m_axis_tready <= 1'b0;
        ready_hold    <= $urandom_range(10, 50);
      end
    end
  end

  // Watchdog: too long without any transfer on either channel ends the run.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 65) begin
      return 0;
    end
    if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Presents one request, waits for it to be taken, then maybe idles a while.
  task automatic send_request(input logic cmd, input logic [BLK_W-1:0] blk);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= blk;
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every result has been taken.
  task automatic drain_results(input int unsigned tail);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [BLK_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  // Sets the volume geometry and, if asked, reloads the free counter.
  task automatic set_volume(input int unsigned start, input int unsigned total,
                            input int unsigned free_cnt, input bit load_free);
    write_reg(CFG_DATA_START, BLK_W'(start));
    write_reg(CFG_TOTAL, BLK_W'(total));
    if (load_free) begin
      write_reg(CFG_INIT_FREE, BLK_W'(free_cnt));
    end
    cfg_we <= 1'b0;
  endtask

  // One random phase: a fresh volume layout, then a mix of allocate and free
  // requests. Most frees aim at the part of the region allocated so far.
  task automatic run_random_phase(input int unsigned n_items);
    int unsigned start;
    int unsigned total;
    int unsigned free_cnt;
    int unsigned region;
    int unsigned alloc_pct;
    int unsigned allocs;
    int unsigned reach;
    int unsigned blk;
    int unsigned r;
    drain_results(CFG_PAUSE);
    case ($urandom_range(0, 9))
      0: begin
        start = 0;
        total = $urandom_range(1, 4096);
      end
      1: begin
        total = 65535;
        start = total - $urandom_range(1, 300);
      end
      2: begin
        start = $urandom_range(0, 65535);
        total = $urandom_range(0, start);
      end
      3: begin
        start = $urandom_range(0, 60000);
        total = start + 4096 + $urandom_range(0, 1400);
      end
      default: begin
        start = $urandom_range(0, 65000);
        total = start + $urandom_range(1, 160);
      end
    endcase
    r = $urandom_range(0, 9);
    free_cnt = (r == 0) ? 0 : (r == 1) ? 4096 : (r == 2) ? CNT_MAX : $urandom_range(0, 4096);
    set_volume(start, total, free_cnt, $urandom_range(0, 4) != 0);

    region = (total > start) ? total - start : 0;
    if (region > MAP_BITS_DEF) begin
      region = MAP_BITS_DEF;
    end
    case ($urandom_range(0, 2))
      0:       alloc_pct = 80;
      1:       alloc_pct = 55;
      default: alloc_pct = 30;
    endcase
    steady_flow <= ($urandom_range(0, 3) == 0);
    allocs = 0;

    repeat (n_items) begin
      if ($urandom_range(0, 99) < alloc_pct) begin
        allocs++;
        send_request(CMD_ALLOC, BLK_W'($urandom_range(0, 65535)));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70 && region != 0) begin
          reach = (region < 2 * allocs + 8) ? region : 2 * allocs + 8;
          blk   = start + $urandom_range(0, reach - 1);
        end else if (r < 85) begin
          // Region edges, just inside and just outside.
          case ($urandom_range(0, 3))
            0:       blk = start - 1;
            1:       blk = start + region;
            2:       blk = start;
            default: blk = start + region - 1;
          endcase
        end else begin
          blk = $urandom_range(0, 65535);
        end
        send_request(CMD_FREE, BLK_W'(blk));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default volume: first fit, reuse of a freed block, free of a free block,
    // and the lowest and highest block numbers.
    send_request(CMD_ALLOC, 16'hFFFF);
    send_request(CMD_ALLOC, 16'h0000);
    send_request(CMD_ALLOC, 16'h0000);
    send_request(CMD_FREE, 16'd1);
    send_request(CMD_ALLOC, 16'h0000);
    send_request(CMD_FREE, 16'd0);
    send_request(CMD_FREE, 16'd3);
    send_request(CMD_FREE, 16'hFFFF);

    // Eight-block region: fill it until full, frees on both sides of it,
    // then a free inside it and an allocate that takes the same block back.
    drain_results(CFG_PAUSE);
    set_volume(100, 108, 8, 1'b1);
    repeat (9) send_request(CMD_ALLOC, 16'h0000);
    send_request(CMD_FREE, 16'd99);
    send_request(CMD_FREE, 16'd108);
    send_request(CMD_FREE, 16'd107);
    send_request(CMD_ALLOC, 16'h0000);

    // Empty region: total equal to the start.
    drain_results(CFG_PAUSE);
    set_volume(200, 200, 0, 1'b1);
    send_request(CMD_ALLOC, 16'h0000);
    send_request(CMD_FREE, 16'd200);

    // Region capped at the map size; the counter stays at zero on allocate.
    drain_results(CFG_PAUSE);
    set_volume(0, 65535, 0, 1'b1);
    send_request(CMD_ALLOC, 16'h0000);

    // Counter loaded above its cap: a free cannot raise it any further.
    drain_results(CFG_PAUSE);
    set_volume(0, 65535, CNT_MAX, 1'b1);
    send_request(CMD_FREE, 16'd9);
    send_request(CMD_ALLOC, 16'h0000);

    repeat (RANDOM_PHASES) begin
      run_random_phase(PHASE_ITEMS);
    end

    drain_results(SETTLE_CYCLES);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> block_bitmap_allocator.f
src/bba_pkg.sv
src/bba_ram.sv
src/bba_engine.sv
src/block_bitmap_allocator.sv
verif/bba_alloc_checker.sv
verif/block_bitmap_allocator_tb.sv
